// ===== design/tmef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmef_pkg
// Shared constants and types for the thermistor median/EMA filter.
// ----------------------------------------------------------------------------
package tmef_pkg;

    localparam int WINDOW_DEF      = 5;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int FRAC_BITS  = 4;
    localparam int FAST_SHIFT = 2;
    localparam int SLOW_SHIFT = 4;
    localparam int DROP_RESET = 10;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index taken from paddr[2]
    localparam logic REG_DROP = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMA,
        ST_OUT
    } t_state;

endpackage

// ===== design/thermistor_median_ema_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_median_ema_filter_unit
// Median of a ring of WINDOW samples followed by an asymmetric Q4 EMA.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------
//  in       | i_in_valid / o_in_stall      | i_raw_sample
//  out      | o_out_valid / i_out_stall    | o_filtered_code, o_median_code,
//           |                              | o_is_seed
//  cfg      | APB psel/penable/pwrite      | drop_threshold at paddr[2] = 0
//
//  One word goes through the steps in order: it is stored, the shared compare
//  row tests up to WINDOW candidates for the median, one candidate per
//  cycle, one EMA update follows, then the result holds until taken.
//  A zero sample is accepted without being stored and gives no result.
//  Synchronous active-low reset; the sample ring needs no clearing.
//  o_in_stall is high from the median scan until the result is taken.
// ----------------------------------------------------------------------------
module thermistor_median_ema_filter_unit #(
    parameter int WINDOW      = tmef_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = tmef_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [SAMPLE_BITS-1:0]          i_raw_sample,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [SAMPLE_BITS-1:0]          o_filtered_code,
    output logic [SAMPLE_BITS-1:0]          o_median_code,
    output logic                            o_is_seed,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmef_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tmef_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tmef_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int ACC_W = SAMPLE_BITS + tmef_pkg::FRAC_BITS;
    localparam int EXT_W = ACC_W + 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW);

    tmef_pkg::t_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_store [WINDOW];
    logic [IDX_W-1:0]       r_slot, n_slot;
    logic                   r_full, n_full;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_cand, n_cand;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic                   r_seeded, n_seeded;
    logic [SAMPLE_BITS-1:0] r_med, n_med;
    logic [SAMPLE_BITS-1:0] r_filt, n_filt;
    logic                   r_is_seed, n_is_seed;
    logic [SAMPLE_BITS-1:0] r_thr;

    logic                   store_en;
    logic                   in_acc;
    logic                   cfg_wr;

    // ---- config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == tmef_pkg::REG_DROP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= SAMPLE_BITS'(tmef_pkg::DROP_RESET);
        end else if (cfg_wr) begin
            r_thr <= pwdata[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == tmef_pkg::REG_DROP) begin
            prdata = tmef_pkg::APB_DATA_W'(r_thr);
        end
    end

    // ---- sample ring
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_store[r_slot] <= i_raw_sample;
        end
    end

    // ---- shared compare row: rank of one candidate against all filled entries
    logic [SAMPLE_BITS-1:0] cand_val;
    logic [CNT_W-1:0]       cnt_lt, cnt_le, half;
    logic                   hit;

    assign cand_val = r_store[r_cand];
    assign half     = r_count >> 1;

    always_comb begin
        cnt_lt = '0;
        cnt_le = '0;
        for (int j = 0; j < WINDOW; j++) begin
            if (CNT_W'(j) < r_count) begin
                cnt_lt = cnt_lt + CNT_W'(r_store[j] <  cand_val);
                cnt_le = cnt_le + CNT_W'(r_store[j] <= cand_val);
            end
        end
    end

    assign hit = (cnt_lt <= half) && (half < cnt_le);

    // ---- EMA step
    logic [SAMPLE_BITS-1:0] prev;
    logic                   go_fast;
    logic [EXT_W-1:0]       acc_fast, acc_slow;
    logic [ACC_W-1:0]       acc_next;

    assign prev    = r_acc[ACC_W-1:tmef_pkg::FRAC_BITS];
    assign go_fast = ({1'b0, r_med} + {1'b0, r_thr}) < {1'b0, prev};
    assign acc_fast = EXT_W'(r_acc) - EXT_W'(r_acc >> tmef_pkg::FAST_SHIFT)
                    + (EXT_W'(r_med) << (tmef_pkg::FRAC_BITS - tmef_pkg::FAST_SHIFT));
    assign acc_slow = EXT_W'(r_acc) - EXT_W'(r_acc >> tmef_pkg::SLOW_SHIFT)
                    + EXT_W'(r_med);

    always_comb begin
        if (!r_seeded) begin
            acc_next = ACC_W'(r_med) << tmef_pkg::FRAC_BITS;
        end else if (go_fast) begin
            acc_next = acc_fast[ACC_W-1:0];
        end else begin
            acc_next = acc_slow[ACC_W-1:0];
        end
    end

    // ---- sequencer
    assign o_in_stall = (r_state != tmef_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign store_en   = in_acc && (i_raw_sample != '0);

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_full    = r_full;
        n_count   = r_count;
        n_cand    = r_cand;
        n_acc     = r_acc;
        n_seeded  = r_seeded;
        n_med     = r_med;
        n_filt    = r_filt;
        n_is_seed = r_is_seed;
        case (r_state)
            tmef_pkg::ST_IDLE: begin
                if (store_en) begin
                    n_cand  = '0;
                    n_state = tmef_pkg::ST_SCAN;
                    if (r_slot == LAST_SLOT) begin
                        n_slot = '0;
                        n_full = 1'b1;
                    end else begin
                        n_slot = r_slot + IDX_W'(1);
                    end
                    if (r_full || (r_slot == LAST_SLOT)) begin
                        n_count = FULL_CNT;
                    end else begin
                        n_count = CNT_W'(r_slot) + CNT_W'(1);
                    end
                end
            end
            tmef_pkg::ST_SCAN: begin
                if (hit) begin
                    n_med   = cand_val;
                    n_state = tmef_pkg::ST_EMA;
                end else begin
                    n_cand = r_cand + IDX_W'(1);
                end
            end
            tmef_pkg::ST_EMA: begin
                n_acc     = acc_next;
                n_filt    = acc_next[ACC_W-1:tmef_pkg::FRAC_BITS];
                n_is_seed = !r_seeded;
                n_seeded  = 1'b1;
                n_state   = tmef_pkg::ST_OUT;
            end
            tmef_pkg::ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = tmef_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tmef_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tmef_pkg::ST_IDLE;
            r_slot   <= '0;
            r_full   <= 1'b0;
            r_count  <= '0;
            r_cand   <= '0;
            r_acc    <= '0;
            r_seeded <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_full   <= n_full;
            r_count  <= n_count;
            r_cand   <= n_cand;
            r_acc    <= n_acc;
            r_seeded <= n_seeded;
        end
    end

    always_ff @(posedge i_clk) begin
        r_med     <= n_med;
        r_filt    <= n_filt;
        r_is_seed <= n_is_seed;
    end

    assign o_out_valid     = (r_state == tmef_pkg::ST_OUT);
    assign o_filtered_code = r_filt;
    assign o_median_code   = r_med;
    assign o_is_seed       = r_is_seed;

    // ---- checks
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmef_pkg::ST_SCAN) |-> (CNT_W'(r_cand) < r_count))
        else $error("median scan ran past filled entries");

    a_seed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_seeded))
        else $error("seed flag cleared outside reset");

    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> (!o_out_valid && !o_in_stall))
        else $error("result word repeated or input not released");

    a_seed_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmef_pkg::ST_EMA && r_seeded) |=> !o_is_seed)
        else $error("seed flag on a later word");

    a_count_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && r_state != tmef_pkg::ST_IDLE) |-> (r_count == FULL_CNT))
        else $error("window count wrong after ring filled");

endmodule

// ===== verif/tmef_filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmef_filter_checker
// Watches the sample, result and APB channels of the thermistor filter. It
// keeps its own median window, Q4 EMA and drop threshold. For each accepted
// nonzero sample it queues the expected reading and compares every accepted
// result word, field by field, against the oldest queued reading. Reads of
// the drop threshold register are checked too. The failure count and the
// number of readings still outstanding go to the testbench top.
// ----------------------------------------------------------------------------
module tmef_filter_checker #(
    parameter int WINDOW      = tmef_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = tmef_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [SAMPLE_BITS-1:0]          i_raw_sample,

    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [SAMPLE_BITS-1:0]          i_filtered_code,
    input  logic [SAMPLE_BITS-1:0]          i_median_code,
    input  logic                            i_is_seed,

    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [tmef_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [tmef_pkg::APB_DATA_W-1:0] i_pwdata,
    input  logic [tmef_pkg::APB_DATA_W-1:0] i_prdata,

    output int                              o_err_cnt,
    output int                              o_pending
);

    localparam int unsigned CODE_MASK = (1 << SAMPLE_BITS) - 1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] filtered;
        logic [SAMPLE_BITS-1:0] median;
        logic                   seed;
    } t_reading;

    logic [SAMPLE_BITS-1:0] ring [WINDOW];
    int                     ring_slot;
    logic                   ring_full;
    int unsigned            ema_acc;
    logic                   ema_seeded;
    logic [SAMPLE_BITS-1:0] drop_thr;
    t_reading               readings_q [$];
    int                     err_total;

    function automatic int unsigned ring_median();
        logic [SAMPLE_BITS-1:0] srt [WINDOW];
        logic [SAMPLE_BITS-1:0] v;
        int                     n;
        int                     j;
        n = ring_full ? WINDOW : ring_slot;
        for (int i = 0; i < n; i++) srt[i] = ring[i];
        for (int i = 1; i < n; i++) begin
            v = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        return srt[n/2];
    endfunction

    task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] s);
        int unsigned med;
        int unsigned prev;
        t_reading    r;
        if (s == '0) return;
        ring[ring_slot] = s;
        ring_slot++;
        if (ring_slot >= WINDOW) begin
            ring_slot = 0;
            ring_full = 1'b1;
        end
        med    = ring_median();
        r.seed = 1'b0;
        if (!ema_seeded) begin
            ema_acc    = med << tmef_pkg::FRAC_BITS;
            ema_seeded = 1'b1;
            r.seed     = 1'b1;
        end else begin
            prev = ema_acc >> tmef_pkg::FRAC_BITS;
            if (med + drop_thr < prev)
                ema_acc = ema_acc - (ema_acc >> tmef_pkg::FAST_SHIFT)
                        + (med << (tmef_pkg::FRAC_BITS - tmef_pkg::FAST_SHIFT));
            else
                ema_acc = ema_acc - (ema_acc >> tmef_pkg::SLOW_SHIFT) + med;
        end
        r.filtered = SAMPLE_BITS'((ema_acc >> tmef_pkg::FRAC_BITS) & CODE_MASK);
        r.median   = SAMPLE_BITS'(med & CODE_MASK);
        readings_q.push_back(r);
    endtask

    task automatic check_word();
        t_reading r;
        if (readings_q.size() == 0) begin
            $display("%0t: result word with none expected (filtered %h median %h seed %b)",
                     $time, i_filtered_code, i_median_code, i_is_seed);
            err_total++;
            return;
        end
        r = readings_q.pop_front();
        if (i_filtered_code !== r.filtered) begin
            $display("%0t: filtered_code exp %h got %h", $time, r.filtered, i_filtered_code);
            err_total++;
        end
        if (i_median_code !== r.median) begin
            $display("%0t: median_code exp %h got %h", $time, r.median, i_median_code);
            err_total++;
        end
        if (i_is_seed !== r.seed) begin
            $display("%0t: is_seed exp %b got %b", $time, r.seed, i_is_seed);
            err_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_slot  = 0;
            ring_full  = 1'b0;
            ema_acc    = 0;
            ema_seeded = 1'b0;
            drop_thr   = SAMPLE_BITS'(tmef_pkg::DROP_RESET);
            readings_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[2] == tmef_pkg::REG_DROP) begin
                if (i_pwrite) begin
                    drop_thr = i_pwdata[SAMPLE_BITS-1:0];
                end else if (i_prdata[SAMPLE_BITS-1:0] !== drop_thr) begin
                    $display("%0t: drop_threshold read exp %h got %h",
                             $time, drop_thr, i_prdata[SAMPLE_BITS-1:0]);
                    err_total++;
                end
            end
            if (i_out_valid && !i_out_stall) check_word();
            if (i_in_valid && !i_in_stall) absorb_sample(i_raw_sample);
        end
        o_err_cnt <= err_total;
        o_pending <= readings_q.size();
    end

endmodule

// ===== verif/thermistor_median_ema_filter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_median_ema_filter_unit_tb
// Drives ADC sample words into the filter under several sender and receiver
// idle mixes and drop thresholds. A directed opening covers code extremes,
// skipped zero samples, seeding, the partly filled window and both EMA
// steps; the random part follows a drifting temperature trend with sharp
// drops, step changes, spikes and raw noise. Checking is done in
// tmef_filter_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module thermistor_median_ema_filter_unit_tb;

    localparam int SB         = tmef_pkg::SAMPLE_BITS_DEF;
    localparam int CODE_MAX   = (1 << SB) - 1;
    localparam int SETTLE     = tmef_pkg::WINDOW_DEF + 7;
    localparam int WATCHDOG   = 4000;
    localparam int PHASES     = 8;
    localparam int PHASE_WORDS = 120;

    localparam logic [tmef_pkg::APB_ADDR_W-1:0] DROP_ADDR  = {tmef_pkg::REG_DROP, 2'b00};
    localparam logic [tmef_pkg::APB_ADDR_W-1:0] SPARE_ADDR = {~tmef_pkg::REG_DROP, 2'b00};

    logic                            i_clk        = 1'b0;
    logic                            i_rst_n      = 1'b0;
    logic                            i_in_valid   = 1'b0;
    logic                            o_in_stall;
    logic [SB-1:0]                   i_raw_sample = '0;
    logic                            o_out_valid;
    logic                            i_out_stall  = 1'b0;
    logic [SB-1:0]                   o_filtered_code;
    logic [SB-1:0]                   o_median_code;
    logic                            o_is_seed;
    logic                            psel         = 1'b0;
    logic                            penable      = 1'b0;
    logic                            pwrite       = 1'b0;
    logic [tmef_pkg::APB_ADDR_W-1:0] paddr        = '0;
    logic [tmef_pkg::APB_DATA_W-1:0] pwdata       = '0;
    logic [tmef_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int err_cnt;
    int pending;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int quiet_cycles  = 0;
    int words_sent    = 0;
    int zeros_sent    = 0;
    int results_seen  = 0;
    int thr_settings  = 0;
    int trend         = 2000;

    always #5 i_clk = ~i_clk;

    thermistor_median_ema_filter_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_raw_sample   (i_raw_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_filtered_code(o_filtered_code),
        .o_median_code  (o_median_code),
        .o_is_seed      (o_is_seed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    tmef_filter_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_raw_sample   (i_raw_sample),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_filtered_code(o_filtered_code),
        .i_median_code  (o_median_code),
        .i_is_seed      (o_is_seed),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .o_err_cnt      (err_cnt),
        .o_pending      (pending)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) results_seen <= results_seen + 1;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("%0t: no progress for %0d cycles, %0d readings outstanding",
                     $time, WATCHDOG, pending);
            $display("thermistor_median_ema_filter_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic send_sample(input logic [SB-1:0] s);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_raw_sample <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
        if (s == '0) zeros_sent++;
    endtask

    task automatic drain_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [tmef_pkg::APB_ADDR_W-1:0] addr,
                              input logic [tmef_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [SB-1:0] thr);
        logic [tmef_pkg::APB_DATA_W-1:0] junk;
        junk = $urandom;
        apb_access(1'b1, DROP_ADDR, {junk[tmef_pkg::APB_DATA_W-1:SB], thr});
        apb_access(1'b0, DROP_ADDR, '0);
        thr_settings++;
    endtask

    function automatic logic [SB-1:0] pick_sample();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 6) return '0;
        if (r < 16) return SB'($urandom_range(CODE_MAX, 0));
        if (r < 22)
            trend = $urandom_range(CODE_MAX, 1);
        else if (r < 30)
            trend = trend - int'($urandom_range(600, 20));
        else
            trend = trend + int'($urandom_range(8)) - 4;
        if (trend < 1) trend = 1;
        if (trend > CODE_MAX) trend = CODE_MAX;
        if (r >= 95)
            v = $urandom_range(CODE_MAX, 1);
        else
            v = trend + int'($urandom_range(6)) - 3;
        if (v < 1) v = 1;
        if (v > CODE_MAX) v = CODE_MAX;
        return SB'(v);
    endfunction

    initial begin
        int             nonzero;
        logic [SB-1:0]  thr;
        logic [SB-1:0]  s;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset threshold: zero skip before seed, seed at full scale,
        // partly filled window, wrap of the ring, bit patterns
        apb_access(1'b0, DROP_ADDR, '0);
        send_sample('0);
        send_sample(SB'(CODE_MAX));
        send_sample('0);
        send_sample(SB'(1));
        send_sample(SB'(1));
        send_sample(SB'('hAAA));
        send_sample(SB'('h555));
        send_sample(SB'('hFFF));
        send_sample(SB'('h800));
        send_sample(SB'('h7FF));
        send_sample(SB'('hFFE));
        send_sample(SB'(2));
        drain_quiet();

        // zero threshold with upper bus bits set; spare address is ignored
        apb_access(1'b1, DROP_ADDR, 32'hFFFF_F000);
        apb_access(1'b1, SPARE_ADDR, 32'h0000_0FFF);
        apb_access(1'b0, DROP_ADDR, '0);
        thr_settings++;
        repeat (5) send_sample(SB'(CODE_MAX));
        send_sample(SB'(CODE_MAX - 1));
        send_sample(SB'(1));
        send_sample(SB'(1));
        send_sample(SB'(1));
        drain_quiet();

        // full-scale threshold: fast step never taken
        set_threshold(SB'(CODE_MAX));
        repeat (3) send_sample(SB'(CODE_MAX));
        drain_quiet();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: thr = '0;
                1: thr = SB'(CODE_MAX);
                2: thr = SB'($urandom_range(40, 1));
                3: thr = SB'($urandom_range(CODE_MAX, 0));
                4: thr = SB'(tmef_pkg::DROP_RESET);
                5: thr = SB'($urandom_range(300, 0));
                6: thr = SB'($urandom_range(20, 0));
                default: thr = SB'($urandom_range(CODE_MAX, 0));
            endcase
            set_threshold(thr);
            case (ph % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 81; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 81; end
                default: begin snd_idle_pct = 13; rcv_stall_pct = 13; end
            endcase
            nonzero = 0;
            while (nonzero < PHASE_WORDS) begin
                s = pick_sample();
                send_sample(s);
                if (s != '0) nonzero++;
            end
            drain_quiet();
        end

        $display("run covered %0d sample words (%0d zero) and %0d result words",
                 words_sent, zeros_sent, results_seen);
        $display("over %0d drop thresholds and four sender/receiver idle mixes",
                 thr_settings);
        if (err_cnt == 0)
            $display("thermistor_median_ema_filter_unit_tb: done, clean");
        else
            $display("thermistor_median_ema_filter_unit_tb: done, errors");
        $finish;
    end

endmodule
